FILE: design/grr_pkg.sv
`timescale 1ns / 1ps

package grr_pkg;

  // Field widths
  localparam int COORD_W     = 13;
  localparam int LINE_W      = 12;
  localparam int MASK_W      = 9;
  localparam int COLOR_W     = 32;
  localparam int BYTE_W      = 8;
  localparam int CHAR_W      = 8;
  localparam int ROW_W       = 4;
  localparam int INDEX_W     = 12;
  localparam int CFG_W       = 13;

  // Screen limits and register reset values
  localparam int SCREEN_MAX   = 4096;
  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    REQ_LOAD   = 1'b0,
    REQ_RENDER = 1'b1
  } req_t;

  typedef enum logic {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
  } grr_screen_t;

  // One classified word travelling from front to back
  typedef struct packed {
    logic                      visible;
    logic [LINE_W-1:0]         line_y;
    logic signed [COORD_W-1:0] x_start;
    logic [COLOR_W-1:0]        color;
    logic [MASK_W-1:0]         clip_mask;
    logic                      bold;
    logic                      uline_row;
    logic                      glyph_ok;
    logic [BYTE_W-1:0]         glyph_byte;
  } grr_entry_t;

endpackage

FILE: design/glyph_row_rasterizer.sv
`timescale 1ns / 1ps
// A word goes from the stage register through a queue slot to the output register.
// Throughput: one word per cycle, load or render, while out_ready stays high.
// A four-entry queue parts the front (store access, clip) from the back (mask, output).
// Reset: synchronous, active low; clears control state, width 640, height 480.
// The glyph store is not cleared by reset and holds whatever was loaded.

module glyph_row_rasterizer #(
  parameter int GLYPH_COUNT = 256,
  parameter int GLYPH_ROWS  = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_req_type,
  input  logic [grr_pkg::INDEX_W-1:0]        in_load_index,
  input  logic [grr_pkg::BYTE_W-1:0]         in_load_byte,
  input  logic [grr_pkg::CHAR_W-1:0]         in_char_code,
  input  logic [grr_pkg::ROW_W-1:0]          in_glyph_row,
  input  logic signed [grr_pkg::COORD_W-1:0] in_x_pos,
  input  logic signed [grr_pkg::COORD_W-1:0] in_y_pos,
  input  logic                               in_bold,
  input  logic                               in_underline,
  input  logic [grr_pkg::COLOR_W-1:0]        in_color,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_row_visible,
  output logic [grr_pkg::LINE_W-1:0]         out_line_y,
  output logic signed [grr_pkg::COORD_W-1:0] out_x_start,
  output logic [grr_pkg::MASK_W-1:0]         out_pixel_mask,
  output logic [grr_pkg::COLOR_W-1:0]        out_color_res,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [grr_pkg::CFG_W-1:0]          cfg_wdata
);

  import grr_pkg::*;

  grr_screen_t         screen_r, screen_nxt;
  logic                push;
  grr_entry_t          push_ent;
  logic                pop;
  logic                head_valid;
  grr_entry_t          head_ent;
  logic [QCNT_W-1:0]   q_count;

  // Screen size registers
  always_comb begin
    screen_nxt = screen_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_WIDTH:  screen_nxt.width  = cfg_wdata;
        CFG_HEIGHT: screen_nxt.height = cfg_wdata;
        default:    screen_nxt = screen_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_r.width  <= CFG_W'(WIDTH_RESET);
      screen_r.height <= CFG_W'(HEIGHT_RESET);
    end else begin
      screen_r <= screen_nxt;
    end
  end

  grr_front #(
    .GLYPH_COUNT (GLYPH_COUNT),
    .GLYPH_ROWS  (GLYPH_ROWS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_load_index (in_load_index),
    .in_load_byte  (in_load_byte),
    .in_char_code  (in_char_code),
    .in_glyph_row  (in_glyph_row),
    .in_x_pos      (in_x_pos),
    .in_y_pos      (in_y_pos),
    .in_bold       (in_bold),
    .in_underline  (in_underline),
    .in_color      (in_color),
    .screen        (screen_r),
    .q_count       (q_count),
    .push          (push),
    .push_ent      (push_ent)
  );

  grr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ent   (push_ent),
    .pop        (pop),
    .head_valid (head_valid),
    .head_ent   (head_ent),
    .count      (q_count)
  );

  grr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head_ent        (head_ent),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_row_visible (out_row_visible),
    .out_line_y      (out_line_y),
    .out_x_start     (out_x_start),
    .out_pixel_mask  (out_pixel_mask),
    .out_color_res   (out_color_res)
  );

endmodule

FILE: design/grr_ram.sv
`timescale 1ns / 1ps

module grr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/grr_front.sv
`timescale 1ns / 1ps

module grr_front #(
  parameter int GLYPH_COUNT = 256,
  parameter int GLYPH_ROWS  = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_req_type,
  input  logic [grr_pkg::INDEX_W-1:0]       in_load_index,
  input  logic [grr_pkg::BYTE_W-1:0]        in_load_byte,
  input  logic [grr_pkg::CHAR_W-1:0]        in_char_code,
  input  logic [grr_pkg::ROW_W-1:0]         in_glyph_row,
  input  logic signed [grr_pkg::COORD_W-1:0] in_x_pos,
  input  logic signed [grr_pkg::COORD_W-1:0] in_y_pos,
  input  logic                              in_bold,
  input  logic                              in_underline,
  input  logic [grr_pkg::COLOR_W-1:0]       in_color,
  input  grr_pkg::grr_screen_t              screen,
  input  logic [grr_pkg::QCNT_W-1:0]        q_count,
  output logic                              push,
  output grr_pkg::grr_entry_t               push_ent
);

  import grr_pkg::*;

  localparam int STORE_DEPTH = GLYPH_COUNT * (2 ** ROW_W);
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  logic                   accept;
  logic                   is_render;
  logic                   glyph_ok;
  logic                   visible;
  logic [COORD_W:0]       line_sum;
  logic [CFG_W-1:0]       height_eff;
  logic [MASK_W-1:0]      clip;
  logic [INDEX_W-1:0]     glyph_addr;
  logic                   ram_we;
  logic                   ram_re;
  logic [BYTE_W-1:0]      ram_rdata;
  logic                   s1_valid_r, s1_valid_nxt;
  grr_entry_t             s1_ent_r, s1_ent_nxt;

  // Credit check: the stage register plus queued words never exceed the queue
  assign in_ready = (q_count + QCNT_W'(s1_valid_r)) < QCNT_W'(QUEUE_DEPTH);
  assign accept   = in_valid && in_ready;

  // Classify the word
  assign is_render = (in_req_type == REQ_RENDER);
  assign glyph_ok  = ({1'b0, in_char_code} < (CHAR_W + 1)'(GLYPH_COUNT)) &&
                     ({1'b0, in_glyph_row} < (ROW_W + 1)'(GLYPH_ROWS));

  // Line visibility; heights above the line range act as the maximum
  assign line_sum   = {in_y_pos[COORD_W-1], in_y_pos} + {{(COORD_W + 1 - ROW_W){1'b0}}, in_glyph_row};
  assign height_eff = (screen.height > CFG_W'(SCREEN_MAX)) ? CFG_W'(SCREEN_MAX) : screen.height;
  assign visible    = is_render && !line_sum[COORD_W] &&
                      (line_sum[COORD_W-1:0] < height_eff);

  // Column clip: keep pixel k only when 0 <= x + k < width
  always_comb begin
    logic [COORD_W:0] px;
    clip = '0;
    for (int k = 0; k < MASK_W; k++) begin
      px      = {in_x_pos[COORD_W-1], in_x_pos} + (COORD_W + 1)'(k);
      clip[k] = !px[COORD_W] && (px[COORD_W-1:0] < screen.width);
    end
  end

  // Glyph store access: loads write, renders read
  assign glyph_addr = {in_char_code, in_glyph_row};
  assign ram_we     = accept && !is_render &&
                      ({1'b0, in_load_index} < (INDEX_W + 1)'(STORE_DEPTH));
  assign ram_re     = accept && is_render && glyph_ok;

  grr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_glyph_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_load_index[ADDR_W-1:0]),
    .wdata (in_load_byte),
    .re    (ram_re),
    .raddr (glyph_addr[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // Stage register next values
  always_comb begin
    s1_valid_nxt = accept;
    s1_ent_nxt   = s1_ent_r;
    if (accept) begin
      s1_ent_nxt.visible    = visible;
      s1_ent_nxt.line_y     = visible ? line_sum[LINE_W-1:0] : '0;
      s1_ent_nxt.x_start    = is_render ? in_x_pos : '0;
      s1_ent_nxt.color      = is_render ? in_color : '0;
      s1_ent_nxt.clip_mask  = visible ? clip : '0;
      s1_ent_nxt.bold       = in_bold;
      s1_ent_nxt.uline_row  = in_underline &&
                              (in_glyph_row == ROW_W'(GLYPH_ROWS - 1));
      s1_ent_nxt.glyph_ok   = is_render && glyph_ok;
      s1_ent_nxt.glyph_byte = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    s1_ent_r <= s1_ent_nxt;
  end

  // Join with the store data, which arrives with the stage register
  always_comb begin
    push_ent            = s1_ent_r;
    push_ent.glyph_byte = ram_rdata;
  end
  assign push = s1_valid_r;

  // The credit check must leave a free slot for every staged word
  a_stage_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (q_count < QCNT_W'(QUEUE_DEPTH)))
    else $error("staged word with no free queue slot");

endmodule

FILE: design/grr_queue.sv
`timescale 1ns / 1ps

module grr_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  grr_pkg::grr_entry_t        push_ent,
  input  logic                       pop,
  output logic                       head_valid,
  output grr_pkg::grr_entry_t        head_ent,
  output logic [grr_pkg::QCNT_W-1:0] count
);

  import grr_pkg::*;

  grr_entry_t          slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_ent;
    end
  end

  assign head_valid = (count_r != '0);
  assign head_ent   = slot_r[rd_ptr_r];
  assign count      = count_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r < QCNT_W'(QUEUE_DEPTH)) || pop)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("queue read while empty");

endmodule

FILE: design/grr_back.sv
`timescale 1ns / 1ps

module grr_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               head_valid,
  input  grr_pkg::grr_entry_t                head_ent,
  output logic                               pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_row_visible,
  output logic [grr_pkg::LINE_W-1:0]         out_line_y,
  output logic signed [grr_pkg::COORD_W-1:0] out_x_start,
  output logic [grr_pkg::MASK_W-1:0]         out_pixel_mask,
  output logic [grr_pkg::COLOR_W-1:0]        out_color_res
);

  import grr_pkg::*;

  logic [MASK_W-1:0]         mask;
  logic                      out_valid_r, out_valid_nxt;
  logic                      visible_r;
  logic [LINE_W-1:0]         line_y_r;
  logic signed [COORD_W-1:0] x_start_r;
  logic [MASK_W-1:0]         mask_r;
  logic [COLOR_W-1:0]        color_r;

  // Take a word whenever the output register is free or being drained
  assign pop = head_valid && (!out_valid_r || out_ready);

  // Glyph byte to pixel mask: msb is pixel 0, then bold, underline, clip
  always_comb begin
    mask = '0;
    if (head_ent.glyph_ok) begin
      for (int k = 0; k < BYTE_W; k++) begin
        mask[k] = head_ent.glyph_byte[BYTE_W-1-k];
      end
    end
    if (head_ent.bold) begin
      mask = mask | (mask << 1);
    end
    if (head_ent.uline_row) begin
      mask = mask | {1'b0, {BYTE_W{1'b1}}};
    end
    mask = mask & head_ent.clip_mask;
  end

  always_comb begin
    out_valid_nxt = pop || (out_valid_r && !out_ready);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (pop) begin
      visible_r <= head_ent.visible;
      line_y_r  <= head_ent.line_y;
      x_start_r <= head_ent.x_start;
      mask_r    <= mask;
      color_r   <= head_ent.color;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_row_visible = visible_r;
  assign out_line_y      = line_y_r;
  assign out_x_start     = x_start_r;
  assign out_pixel_mask  = mask_r;
  assign out_color_res   = color_r;

  a_hidden_line_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !visible_r) |-> (mask_r == '0) && (line_y_r == '0))
    else $error("hidden line carries pixels or a line number");

endmodule

FILE: bench/grr_line_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the register port, works out the line word each
// accepted input word should give and compares it with what comes out.
module grr_line_checker #(
  parameter int GLYPH_COUNT = 256,
  parameter int GLYPH_ROWS  = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic                               in_req_type,
  input  logic [grr_pkg::INDEX_W-1:0]        in_load_index,
  input  logic [grr_pkg::BYTE_W-1:0]         in_load_byte,
  input  logic [grr_pkg::CHAR_W-1:0]         in_char_code,
  input  logic [grr_pkg::ROW_W-1:0]          in_glyph_row,
  input  logic signed [grr_pkg::COORD_W-1:0] in_x_pos,
  input  logic signed [grr_pkg::COORD_W-1:0] in_y_pos,
  input  logic                               in_bold,
  input  logic                               in_underline,
  input  logic [grr_pkg::COLOR_W-1:0]        in_color,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic                               out_row_visible,
  input  logic [grr_pkg::LINE_W-1:0]         out_line_y,
  input  logic signed [grr_pkg::COORD_W-1:0] out_x_start,
  input  logic [grr_pkg::MASK_W-1:0]         out_pixel_mask,
  input  logic [grr_pkg::COLOR_W-1:0]        out_color_res,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [grr_pkg::CFG_W-1:0]          cfg_wdata,
  output int                                 mismatches,
  output int                                 lines_pending,
  output int                                 lines_checked
);

  import grr_pkg::*;

  typedef struct packed {
    logic                      visible;
    logic [LINE_W-1:0]         line_y;
    logic signed [COORD_W-1:0] x_start;
    logic [MASK_W-1:0]         mask;
    logic [COLOR_W-1:0]        color;
  } line_word_t;

  // own copy of the font and the screen size
  logic [BYTE_W-1:0] glyph_copy [0:(1 << INDEX_W) - 1];
  logic [CFG_W-1:0]  screen_w;
  logic [CFG_W-1:0]  screen_h;
  line_word_t        lines_due [$];

  // One glyph row turned into a clipped pixel mask on its screen line
  function automatic line_word_t render_line(
    input logic [CHAR_W-1:0]         ch,
    input logic [ROW_W-1:0]          row,
    input logic signed [COORD_W-1:0] x,
    input logic signed [COORD_W-1:0] y,
    input logic                      bold,
    input logic                      uline,
    input logic [COLOR_W-1:0]        color
  );
    line_word_t        res;
    logic [BYTE_W-1:0] bits;
    logic [MASK_W-1:0] m;
    int                line;
    int                height;
    int                px;
    res         = '0;
    res.x_start = x;
    res.color   = color;
    height = (int'(screen_h) > SCREEN_MAX) ? SCREEN_MAX : int'(screen_h);
    line   = int'(y) + int'(row);
    if (line < 0 || line >= height) return res;

    // glyphs beyond the font size read as blank
    bits = '0;
    if (int'(ch) < GLYPH_COUNT && int'(row) < GLYPH_ROWS) bits = glyph_copy[{ch, row}];

    // msb of the byte is mask bit 0
    m = '0;
    for (int k = 0; k < BYTE_W; k++) m[k] = bits[BYTE_W-1-k];
    if (bold) m = m | (m << 1);
    if (uline && int'(row) == GLYPH_ROWS - 1) m[BYTE_W-1:0] = '1;

    // column clip
    for (int k = 0; k < MASK_W; k++) begin
      px = int'(x) + k;
      if (px < 0 || px >= int'(screen_w)) m[k] = 1'b0;
    end

    res.visible = 1'b1;
    res.line_y  = line[LINE_W-1:0];
    res.mask    = m;
    return res;
  endfunction

  task automatic check_field(input string name, input logic signed [63:0] exp_v,
                             input logic signed [63:0] act_v);
    if (act_v !== exp_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    line_word_t want;
    line_word_t got;
    if (!rst_n) begin
      screen_w = CFG_W'(WIDTH_RESET);
      screen_h = CFG_W'(HEIGHT_RESET);
      lines_due.delete();
    end else begin
      // register writes must only be made while the block is idle; the block does not enforce it
      if (cfg_we) begin
        if (cfg_index == CFG_WIDTH) screen_w = cfg_wdata;
        else screen_h = cfg_wdata;
      end

      // result side
      if (out_valid && out_ready) begin
        got.visible = out_row_visible;
        got.line_y  = out_line_y;
        got.x_start = out_x_start;
        got.mask    = out_pixel_mask;
        got.color   = out_color_res;
        if (lines_due.size() == 0) begin
          mismatches++;
          $display("%0t: result word with none expected, got line_y %0d x_start %0d mask %0d",
                   $time, got.line_y, got.x_start, got.mask);
        end else begin
          want = lines_due.pop_front();
          check_field("row_visible", 64'(want.visible), 64'(got.visible));
          check_field("line_y", 64'(want.line_y), 64'(got.line_y));
          check_field("x_start", 64'(want.x_start), 64'(got.x_start));
          check_field("pixel_mask", 64'(want.mask), 64'(got.mask));
          check_field("color_res", 64'(want.color), 64'(got.color));
          lines_checked++;
        end
      end

      // input side: a load updates the font and gives an all-zero word
      if (in_valid && in_ready) begin
        if (in_req_type == REQ_LOAD) begin
          glyph_copy[in_load_index] = in_load_byte;
          lines_due.push_back('0);
        end else begin
          lines_due.push_back(render_line(in_char_code, in_glyph_row, in_x_pos, in_y_pos,
                                          in_bold, in_underline, in_color));
        end
      end
    end
    lines_pending = lines_due.size();
  end

endmodule

FILE: bench/glyph_row_rasterizer_tb.sv
`timescale 1ns / 1ps

module glyph_row_rasterizer_tb;
  import grr_pkg::*;

  localparam int GLYPHS          = 256;
  localparam int ROWS            = 16;
  localparam int PHASES          = 7;
  localparam int WORDS_PER_PHASE = 190;
  localparam int DRAIN_CYCLES    = 8;
  localparam int STALL_LIMIT     = 1000;
  localparam int GLYPH_STEP      = 8;

  typedef struct {
    req_t                      kind;
    logic [INDEX_W-1:0]        index;
    logic [BYTE_W-1:0]         data;
    logic [CHAR_W-1:0]         ch;
    logic [ROW_W-1:0]          row;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      bold;
    logic                      uline;
    logic [COLOR_W-1:0]        color;
  } glyph_word_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic                      in_req_type;
  logic [INDEX_W-1:0]        in_load_index;
  logic [BYTE_W-1:0]         in_load_byte;
  logic [CHAR_W-1:0]         in_char_code;
  logic [ROW_W-1:0]          in_glyph_row;
  logic signed [COORD_W-1:0] in_x_pos;
  logic signed [COORD_W-1:0] in_y_pos;
  logic                      in_bold;
  logic                      in_underline;
  logic [COLOR_W-1:0]        in_color;
  logic                      out_valid;
  logic                      out_ready;
  logic                      out_row_visible;
  logic [LINE_W-1:0]         out_line_y;
  logic signed [COORD_W-1:0] out_x_start;
  logic [MASK_W-1:0]         out_pixel_mask;
  logic [COLOR_W-1:0]        out_color_res;
  logic                      cfg_we;
  logic                      cfg_index;
  logic [CFG_W-1:0]          cfg_wdata;

  int mismatches;
  int lines_pending;
  int lines_checked;

  // stimulus bookkeeping
  bit                 glyph_written [0:(1 << INDEX_W) - 1];
  logic [INDEX_W-1:0] glyphs_loaded [$];
  int                 scr_w = WIDTH_RESET;
  int                 scr_h = HEIGHT_RESET;
  int                 words_sent;
  int                 loads_sent;
  int                 renders_sent;
  int                 screens = 1;
  int                 idle_cycles;
  bit                 steady;
  bit                 calm_run;

  glyph_row_rasterizer #(
    .GLYPH_COUNT (GLYPHS),
    .GLYPH_ROWS  (ROWS)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_load_index   (in_load_index),
    .in_load_byte    (in_load_byte),
    .in_char_code    (in_char_code),
    .in_glyph_row    (in_glyph_row),
    .in_x_pos        (in_x_pos),
    .in_y_pos        (in_y_pos),
    .in_bold         (in_bold),
    .in_underline    (in_underline),
    .in_color        (in_color),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_row_visible (out_row_visible),
    .out_line_y      (out_line_y),
    .out_x_start     (out_x_start),
    .out_pixel_mask  (out_pixel_mask),
    .out_color_res   (out_color_res),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  grr_line_checker #(
    .GLYPH_COUNT (GLYPHS),
    .GLYPH_ROWS  (ROWS)
  ) u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_load_index   (in_load_index),
    .in_load_byte    (in_load_byte),
    .in_char_code    (in_char_code),
    .in_glyph_row    (in_glyph_row),
    .in_x_pos        (in_x_pos),
    .in_y_pos        (in_y_pos),
    .in_bold         (in_bold),
    .in_underline    (in_underline),
    .in_color        (in_color),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_row_visible (out_row_visible),
    .out_line_y      (out_line_y),
    .out_x_start     (out_x_start),
    .out_pixel_mask  (out_pixel_mask),
    .out_color_res   (out_color_res),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .mismatches      (mismatches),
    .lines_pending   (lines_pending),
    .lines_checked   (lines_checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result side back-pressure: short stalls, the odd long clear run
  initial begin
    out_ready = 1'b1;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!steady && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end else if ($urandom_range(0, 40) == 0) begin
        repeat ($urandom_range(20, 60)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // watchdog on cycles where no word moves
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
      idle_cycles <= 0;
    else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  function automatic logic signed [COORD_W-1:0] to_coord(input int v);
    int lo;
    int hi;
    lo = -(1 << (COORD_W - 1));
    hi = (1 << (COORD_W - 1)) - 1;
    if (v < lo) v = lo;
    else if (v > hi) v = hi;
    return v[COORD_W-1:0];
  endfunction

  // every field but the kind random, so unused fields toggle too
  function automatic glyph_word_t random_word();
    glyph_word_t w;
    w.kind  = REQ_LOAD;
    w.index = INDEX_W'($urandom);
    w.data  = BYTE_W'($urandom);
    w.ch    = CHAR_W'($urandom);
    w.row   = ROW_W'($urandom);
    w.x     = COORD_W'($urandom);
    w.y     = COORD_W'($urandom);
    w.bold  = 1'($urandom);
    w.uline = 1'($urandom);
    w.color = $urandom;
    return w;
  endfunction

  // glyph left edge: anywhere, around column 0, around the right edge, or inside
  function automatic int pick_x();
    logic [COORD_W-1:0] raw;
    raw = COORD_W'($urandom);
    case ($urandom_range(0, 4))
      0:       return int'($signed(raw));
      1:       return int'($urandom_range(0, 18)) - 9;
      2:       return scr_w - 9 + int'($urandom_range(0, 10));
      default: return int'($urandom_range(0, scr_w - 1));
    endcase
  endfunction

  // target screen line, same spread as the columns
  function automatic int pick_line();
    logic [COORD_W-1:0] raw;
    raw = COORD_W'($urandom);
    case ($urandom_range(0, 4))
      0:       return int'($signed(raw));
      1:       return int'($urandom_range(0, 6)) - 3;
      2:       return scr_h - 3 + int'($urandom_range(0, 5));
      default: return int'($urandom_range(0, scr_h - 1));
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return 8'h80;
      3:       return 8'h01;
      default: return BYTE_W'($urandom);
    endcase
  endfunction

  task automatic send_word(input glyph_word_t w);
    if (!steady && !calm_run && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_req_type   <= w.kind;
    in_load_index <= w.index;
    in_load_byte  <= w.data;
    in_char_code  <= w.ch;
    in_glyph_row  <= w.row;
    in_x_pos      <= w.x;
    in_y_pos      <= w.y;
    in_bold       <= w.bold;
    in_underline  <= w.uline;
    in_color      <= w.color;
    in_valid      <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    words_sent++;
    if (w.kind == REQ_LOAD) begin
      loads_sent++;
      if (!glyph_written[w.index]) begin
        glyph_written[w.index] = 1'b1;
        glyphs_loaded.push_back(w.index);
      end
    end else
      renders_sent++;
  endtask

  task automatic send_load(input logic [INDEX_W-1:0] idx, input logic [BYTE_W-1:0] data);
    glyph_word_t w;
    w       = random_word();
    w.kind  = REQ_LOAD;
    w.index = idx;
    w.data  = data;
    send_word(w);
  endtask

  task automatic send_render(input logic [INDEX_W-1:0] idx, input int x, input int y,
                             input logic bold, input logic uline,
                             input logic [COLOR_W-1:0] color);
    glyph_word_t w;
    w       = random_word();
    w.kind  = REQ_RENDER;
    w.ch    = idx[INDEX_W-1:ROW_W];
    w.row   = idx[ROW_W-1:0];
    w.x     = to_coord(x);
    w.y     = to_coord(y);
    w.bold  = bold;
    w.uline = uline;
    w.color = color;
    send_word(w);
  endtask

  // load a whole glyph, or a handful of scattered rows of one
  task automatic define_glyph();
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0]  row_sel;
    int                rows;
    ch   = CHAR_W'($urandom);
    rows = $urandom_range(0, 1) ? ROWS : $urandom_range(1, 6);
    for (int r = 0; r < rows; r++) begin
      row_sel = (rows == ROWS) ? r[ROW_W-1:0] : ROW_W'($urandom);
      send_load({ch, row_sel}, pick_byte());
    end
  endtask

  // a run of loaded glyph rows laid out along one screen line
  task automatic render_run();
    logic [INDEX_W-1:0] idx;
    int                 count;
    int                 line;
    int                 x;
    count = $urandom_range(1, 8);
    line  = pick_line();
    x     = pick_x();
    repeat (count) begin
      idx = glyphs_loaded[$urandom_range(0, glyphs_loaded.size() - 1)];
      send_render(idx, x, line - int'(idx[ROW_W-1:0]), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), $urandom);
      x = x + GLYPH_STEP;
    end
  endtask

  // registers change only once the pipe has drained
  task automatic set_screen(input int w, input int h);
    in_valid <= 1'b0;
    while (lines_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WIDTH;
    cfg_wdata <= w[CFG_W-1:0];
    @(negedge clk);
    cfg_index <= CFG_HEIGHT;
    cfg_wdata <= h[CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    scr_w = w;
    scr_h = h;
    screens++;
  endtask

  initial begin
    int target;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_req_type   = REQ_LOAD;
    in_load_index = '0;
    in_load_byte  = '0;
    in_char_code  = '0;
    in_glyph_row  = '0;
    in_x_pos      = '0;
    in_y_pos      = '0;
    in_bold       = 1'b0;
    in_underline  = 1'b0;
    in_color      = '0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_WIDTH;
    cfg_wdata     = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // font extremes and a few edge patterns
    send_load(12'h000, 8'hFF);
    send_load(12'hFFF, 8'h81);
    send_load(12'h41F, 8'h00);
    send_load(12'h417, 8'h80);
    send_load(12'h418, 8'h01);
    send_load(12'hAAA, 8'h55);
    send_load(12'h555, 8'hAA);
    // origin, then both corners of the coordinate range (off screen)
    send_render(12'h000, 0, 0, 1'b0, 1'b0, 32'h0000_0000);
    send_render(12'h000, -4096, -4096, 1'b1, 1'b1, 32'hFFFF_FFFF);
    send_render(12'hFFF, 4095, 4095, 1'b1, 1'b1, 32'h8000_0001);
    // bottom screen line, bold pixel lost at the right edge
    send_render(12'hFFF, 632, 464, 1'b1, 1'b1, 32'h1234_5678);
    // first line below the screen
    send_render(12'hFFF, -3, 465, 1'b0, 1'b1, 32'hA5A5_5A5A);
    // underline bar on a blank bottom row, line 0
    send_render(12'h41F, 10, -15, 1'b1, 1'b1, 32'h0F0F_0F0F);
    // leftmost pixel clipped, its bold copy kept
    send_render(12'h417, -1, -7, 1'b1, 1'b0, 32'h0000_00FF);
    // rightmost pixel and bold copy both just inside
    send_render(12'h418, 631, 100, 1'b1, 1'b0, 32'hFF00_0000);
    // underline flag on a row that is not the bottom one
    send_render(12'hAAA, 100, 200, 1'b0, 1'b1, 32'h5555_AAAA);
    // glyph wholly right of the screen, then wholly left of it, then straddling the left edge
    send_render(12'h555, 640, 300, 1'b1, 1'b1, 32'h0000_0001);
    send_render(12'h555, -9, 300, 1'b1, 1'b0, 32'h7FFF_FFFF);
    send_render(12'h555, -8, 300, 1'b1, 1'b0, 32'hDEAD_0000);

    // random phases, each under its own screen size
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        1:       set_screen(1, 1);
        2:       set_screen(SCREEN_MAX, SCREEN_MAX);
        3:       set_screen(1, SCREEN_MAX);
        4:       set_screen(SCREEN_MAX, 1);
        5:       set_screen($urandom_range(2, 64), $urandom_range(2, 64));
        6:       set_screen($urandom_range(1, SCREEN_MAX), $urandom_range(1, SCREEN_MAX));
        default: ;
      endcase
      steady = (p == PHASES - 1);
      target = words_sent + WORDS_PER_PHASE;
      while (words_sent < target) begin
        calm_run = ($urandom_range(0, 3) == 0);
        if (glyphs_loaded.size() == 0 || $urandom_range(0, 9) < 3) define_glyph();
        else render_run();
      end
    end

    in_valid <= 1'b0;
    while (lines_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("run covered %0d words (%0d glyph loads, %0d row renders) over %0d screen sizes",
             words_sent, loads_sent, renders_sent, screens);
    $display("%0d result words compared, %0d field mismatches", lines_checked, mismatches);
    if (mismatches == 0 && lines_pending == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

FILE: files.f
design/grr_pkg.sv
design/grr_ram.sv
design/grr_front.sv
design/grr_queue.sv
design/grr_back.sv
design/glyph_row_rasterizer.sv
bench/grr_line_checker.sv
bench/glyph_row_rasterizer_tb.sv
